// File: rtl/core/oab_pkg.sv
// Shared types, constants and the tangent table for the octant atan2 block.
// Used by oab_div, oab_search and octant_atan2_binary_angle; depends on nothing.
package oab_pkg;

  localparam int CompW   = 32;          // width of one vector component
  localparam int MagW    = 32;          // magnitude width, 2^31 still fits unsigned
  localparam int QuoW    = 14;          // ratio min/max scaled by 8192, at most 8192
  localparam int IdxW    = 6;           // table index 0..32
  localparam int AngW    = 8;           // binary angle width

  localparam logic [IdxW-1:0] TabLast = 6'd32;

  localparam logic [AngW-1:0] AngPosX = 8'd0;
  localparam logic [AngW-1:0] AngPosY = 8'd64;
  localparam logic [AngW-1:0] AngNegX = 8'd128;
  localparam logic [AngW-1:0] AngNegY = 8'd192;

  // Divider status toward the control
  typedef struct packed {
    logic            done;
    logic [QuoW-1:0] quo;
  } div_res_t;

  // Table search status toward the control
  typedef struct packed {
    logic            done;
    logic [IdxW-1:0] idx;
  } srch_res_t;

  // Entry i is trunc(tan(2*pi*i/256) * 8192)
  function automatic logic [QuoW-1:0] tan_entry(input logic [IdxW-1:0] i);
    logic [QuoW-1:0] v;
    case (i)
      6'd0:    v = 14'd0;
      6'd1:    v = 14'd201;
      6'd2:    v = 14'd402;
      6'd3:    v = 14'd604;
      6'd4:    v = 14'd806;
      6'd5:    v = 14'd1010;
      6'd6:    v = 14'd1215;
      6'd7:    v = 14'd1421;
      6'd8:    v = 14'd1629;
      6'd9:    v = 14'd1839;
      6'd10:   v = 14'd2051;
      6'd11:   v = 14'd2267;
      6'd12:   v = 14'd2485;
      6'd13:   v = 14'd2706;
      6'd14:   v = 14'd2931;
      6'd15:   v = 14'd3160;
      6'd16:   v = 14'd3393;
      6'd17:   v = 14'd3631;
      6'd18:   v = 14'd3874;
      6'd19:   v = 14'd4123;
      6'd20:   v = 14'd4378;
      6'd21:   v = 14'd4640;
      6'd22:   v = 14'd4910;
      6'd23:   v = 14'd5187;
      6'd24:   v = 14'd5473;
      6'd25:   v = 14'd5769;
      6'd26:   v = 14'd6075;
      6'd27:   v = 14'd6393;
      6'd28:   v = 14'd6723;
      6'd29:   v = 14'd7066;
      6'd30:   v = 14'd7424;
      6'd31:   v = 14'd7799;
      default: v = 14'd8192;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/oab_div.sv
// Bit-serial restoring divider: (num * 8192) / den, one quotient bit per cycle.
// Depends on oab_pkg. Expects num <= den and den != 0.
module oab_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [oab_pkg::MagW-1:0] num_i,
  input  logic [oab_pkg::MagW-1:0] den_i,
  output oab_pkg::div_res_t        res_o
);
  import oab_pkg::*;

  localparam logic [3:0] CntInit = 4'(QuoW - 1);

  logic [MagW:0]   rem_q, rem_d;
  logic [MagW-1:0] den_q;
  logic [QuoW-1:0] quo_q;
  logic [3:0]      cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [MagW+1:0] diff;
  logic            ge;
  logic [MagW:0]   rem_keep;

  // Trial subtract of the divisor from the partial remainder
  always_comb begin
    diff     = {1'b0, rem_q} - {2'b00, den_q};
    ge       = ~diff[MagW+1];
    rem_keep = ge ? diff[MagW:0] : rem_q;
    rem_d    = {rem_keep[MagW-1:0], 1'b0};
  end

  // Control: count the quotient bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntInit;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: shift the remainder and the quotient bits
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QuoW-2:0], ge};
    end
  end

  assign res_o.done = done_q;
  assign res_o.quo  = quo_q;

endmodule

// File: rtl/core/oab_search.sv
// Serial scan of the tangent table, one entry per cycle, for the first
// entry not below the ratio. Depends on oab_pkg.
module oab_search (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [oab_pkg::QuoW-1:0] ratio_i,
  output oab_pkg::srch_res_t       res_o
);
  import oab_pkg::*;

  logic [QuoW-1:0] ratio_q;
  logic [IdxW-1:0] idx_q;
  logic            busy_q;
  logic            done_q;
  logic            hit;

  // Stop at the last entry or at the first entry that covers the ratio
  assign hit = (idx_q == TabLast) || (ratio_q <= tan_entry(idx_q));

  // Advance the index until a hit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (busy_q) begin
        if (hit) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          idx_q <= idx_q + 6'd1;
        end
      end
    end
  end

  // Hold the ratio for the scan
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ratio_q <= ratio_i;
    end
  end

  assign res_o.done = done_q;
  assign res_o.idx  = idx_q;

endmodule

// File: rtl/core/octant_atan2_binary_angle.sv
// Direction of a signed (x, y) vector as an 8-bit binary angle.
// Depends on oab_pkg, oab_div and oab_search.
//
// Usage:
//   Input channel: vec_x_i, vec_y_i, fallback_angle_i with in_valid_i and
//   in_stall_o; a request is taken at a clock edge with valid high and
//   stall low. Output channel: angle_o with out_valid_o and out_stall_i.
//   One request is worked on at a time; in_stall_o is high while it is.
//   A vector on an axis, or the zero vector, goes from acceptance straight
//   to the hand-off state. Any other vector goes through the bit-serial
//   divider, then the one-entry-per-cycle table scan, which stops at the
//   table index found (0..32), plus control and output stages.
//   A finished angle sits in the output register while the receiver
//   stalls; the next request is accepted meanwhile, and its own result
//   waits in the control until the output register is taken.
//   Reset (rst_ni low, asynchronous) drops any request in flight and
//   clears out_valid_o.
module octant_atan2_binary_angle (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic signed [oab_pkg::CompW-1:0] vec_x_i,
  input  logic signed [oab_pkg::CompW-1:0] vec_y_i,
  input  logic [oab_pkg::AngW-1:0]        fallback_angle_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  output logic [oab_pkg::AngW-1:0]        angle_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i
);
  import oab_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StSrch = 2'd2;
  localparam logic [1:0] StFin  = 2'd3;

  logic [1:0]      state_q, state_d;
  logic            xneg_q, yneg_q, xgt_q;
  logic [AngW-1:0] ans_q, ans_d;
  logic [AngW-1:0] angle_q;
  logic            out_valid_q;

  logic            accept;
  logic            xneg, yneg, xzero, yzero, axis;
  logic [MagW-1:0] ax, ay, num, den;
  logic            xgt;
  logic [AngW-1:0] axis_ang;
  logic [AngW-1:0] idx_ext;
  logic [AngW-1:0] fold_ang;
  logic            out_free;
  logic            div_start, srch_start;
  div_res_t        div_res;
  srch_res_t       srch_res;

  assign accept   = in_valid_i && (state_q == StIdle);
  assign out_free = !out_valid_q || !out_stall_i;

  // Magnitudes and octant of the incoming request
  always_comb begin
    xneg  = vec_x_i[CompW-1];
    yneg  = vec_y_i[CompW-1];
    xzero = (vec_x_i == '0);
    yzero = (vec_y_i == '0);
    axis  = xzero || yzero;
    ax    = xneg ? (~vec_x_i + 32'd1) : vec_x_i;
    ay    = yneg ? (~vec_y_i + 32'd1) : vec_y_i;
    xgt   = (ax > ay);
    num   = xgt ? ay : ax;
    den   = xgt ? ax : ay;
    if (xzero && yzero) begin
      axis_ang = fallback_angle_i;
    end else if (yzero) begin
      axis_ang = xneg ? AngNegX : AngPosX;
    end else begin
      axis_ang = yneg ? AngNegY : AngPosY;
    end
  end

  // Fold the table index by octant, wrapping modulo 256
  always_comb begin
    idx_ext = {2'b00, srch_res.idx};
    case ({xneg_q, yneg_q})
      2'b00:   fold_ang = xgt_q ? idx_ext : (AngPosY - idx_ext);
      2'b01:   fold_ang = xgt_q ? (AngPosX - idx_ext) : (AngNegY + idx_ext);
      2'b10:   fold_ang = xgt_q ? (AngNegX - idx_ext) : (AngPosY + idx_ext);
      default: fold_ang = xgt_q ? (AngNegX + idx_ext) : (AngNegY - idx_ext);
    endcase
  end

  assign div_start  = accept && !axis;
  assign srch_start = (state_q == StDiv) && div_res.done;

  oab_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (den),
    .res_o   (div_res)
  );

  oab_search u_search (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (srch_start),
    .ratio_i (div_res.quo),
    .res_o   (srch_res)
  );

  // Sequence one request through divide, scan and hand-off; axis and zero vectors go straight to hand-off
  always_comb begin
    state_d = state_q;
    ans_d   = ans_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (axis) begin
            ans_d   = axis_ang;
            state_d = StFin;
          end else begin
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        if (div_res.done) begin
          state_d = StSrch;
        end
      end
      StSrch: begin
        if (srch_res.done) begin
          ans_d   = fold_ang;
          state_d = StFin;
        end
      end
      default: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
    endcase
  end

  // Control state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == StFin) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload: octant flags, pending angle, output register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      xneg_q <= xneg;
      yneg_q <= yneg;
      xgt_q  <= xgt;
    end
    ans_q <= ans_d;
    if ((state_q == StFin) && out_free) begin
      angle_q <= ans_q;
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign angle_o     = angle_q;
  assign out_valid_o = out_valid_q;

`ifndef ASSERT_OFF
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_res.done |-> (state_q == StDiv))
    else $error("divider finished outside the divide phase");

  a_srch_done_in_srch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    srch_res.done |-> (state_q == StSrch))
    else $error("table scan finished outside the scan phase");

  a_axis_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && axis) |=> (state_q == StFin))
    else $error("axis request did not go straight to hand-off");

  a_handoff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StFin) && out_free) |=> (out_valid_q && (angle_q == $past(ans_q))))
    else $error("finished angle not loaded into the output register");
`endif

endmodule

// File: tb/sv/octant_atan2_binary_angle_test.sv
`timescale 1ns / 1ps
// Testbench for octant_atan2_binary_angle: directed and random vectors, a self-built
// angle predictor and an in-order result check. Depends on oab_pkg and the block's RTL.
module octant_atan2_binary_angle_test;
  import oab_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 60;
  localparam int LastIndex   = 32;

  typedef struct {
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    logic [AngW-1:0]         angle;
  } angle_expect_t;

  logic                    clk_i            = 1'b0;
  logic                    rst_ni           = 1'b0;
  logic signed [CompW-1:0] vec_x_i          = '0;
  logic signed [CompW-1:0] vec_y_i          = '0;
  logic [AngW-1:0]         fallback_angle_i = '0;
  logic                    in_valid_i       = 1'b0;
  logic                    in_stall_o;
  logic [AngW-1:0]         angle_o;
  logic                    out_valid_o;
  logic                    out_stall_i      = 1'b0;

  angle_expect_t expected_angles[$];
  int            send_idle_pct = 0;
  int            stall_pct     = 0;
  int            hold_off_req  = 0;
  int            fail_cnt      = 0;
  int            cycle_cnt     = 0;

  // Tangent bounds scaled by 8192, one per table index
  int unsigned tan_bound [0:32] = '{
       0,  201,  402,  604,  806, 1010, 1215, 1421,
    1629, 1839, 2051, 2267, 2485, 2706, 2931, 3160,
    3393, 3631, 3874, 4123, 4378, 4640, 4910, 5187,
    5473, 5769, 6075, 6393, 6723, 7066, 7424, 7799,
    8192
  };

  octant_atan2_binary_angle u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .vec_x_i          (vec_x_i),
    .vec_y_i          (vec_y_i),
    .fallback_angle_i (fallback_angle_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .angle_o          (angle_o),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // First table index whose bound is not below minor * 8192 / major
  function automatic logic [AngW-1:0] tan_index(input logic [MagW-1:0] minor,
                                                input logic [MagW-1:0] major);
    logic [63:0] ratio;
    int          i;
    ratio = ({32'd0, minor} << 13) / {32'd0, major};
    i = 0;
    while (i < LastIndex && ratio > tan_bound[i]) i++;
    return AngW'(i);
  endfunction

  // Expected binary angle of one vector
  function automatic logic [AngW-1:0] predict_angle(input logic signed [CompW-1:0] x,
                                                    input logic signed [CompW-1:0] y,
                                                    input logic [AngW-1:0] fallback);
    logic [MagW-1:0] mag_x;
    logic [MagW-1:0] mag_y;
    logic            x_major;
    logic [AngW-1:0] idx;
    mag_x   = x[CompW-1] ? (~x + 1'b1) : x;
    mag_y   = y[CompW-1] ? (~y + 1'b1) : y;
    x_major = mag_x > mag_y;
    idx     = x_major ? tan_index(mag_y, mag_x) : tan_index(mag_x, mag_y);
    if (x == 0 && y == 0) return fallback;
    if (y == 0) return x[CompW-1] ? AngNegX : AngPosX;
    if (x == 0) return y[CompW-1] ? AngNegY : AngPosY;
    // Fold the first-octant index into the vector's octant; wrap mod 256
    if (!x[CompW-1] && !y[CompW-1]) return x_major ? AngPosX + idx : AngPosY - idx;
    if (!x[CompW-1])                return x_major ? AngPosX - idx : AngNegY + idx;
    if (!y[CompW-1])                return x_major ? AngNegX - idx : AngPosY + idx;
    return x_major ? AngNegX + idx : AngNegY - idx;
  endfunction

  function automatic logic signed [CompW-1:0] signed_of(input logic [MagW-1:0] mag,
                                                        input logic neg);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
    fail_cnt++;
  endtask

  // Offer one request, hold it until taken, then record its expected angle
  task automatic send_vector(input logic signed [CompW-1:0] x,
                             input logic signed [CompW-1:0] y,
                             input logic [AngW-1:0] fallback);
    angle_expect_t item;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    vec_x_i          <= x;
    vec_y_i          <= y;
    fallback_angle_i <= fallback;
    in_valid_i       <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    item.x     = x;
    item.y     = y;
    item.angle = predict_angle(x, y, fallback);
    expected_angles.push_back(item);
  endtask

  // Draw one random request from a mix of shapes
  task automatic send_random_vector();
    int unsigned           kind;
    int unsigned           k;
    logic [MagW-1:0]       major;
    logic [63:0]           minor;
    logic signed [CompW-1:0] x;
    logic signed [CompW-1:0] y;
    kind = $urandom_range(99);
    x    = $urandom;
    y    = $urandom;
    if (kind >= 45 && kind < 60) begin
      // small magnitudes
      x = $signed($urandom_range(600)) - 300;
      y = $signed($urandom_range(600)) - 300;
    end else if (kind >= 60 && kind < 70) begin
      // axes, zero vector and the most negative component
      case ($urandom_range(5))
        0: begin x = 0; y = 0; end
        1: y = 0;
        2: x = 0;
        3: begin x = 32'sh8000_0000; y = $urandom_range(1) ? 0 : y; end
        4: begin y = 32'sh8000_0000; x = $urandom_range(1) ? 0 : x; end
        default: begin x = 0; y = 0; end
      endcase
    end else if (kind >= 70 && kind < 85) begin
      // land on either side of a tangent boundary
      k     = $urandom_range(LastIndex);
      major = $urandom_range(1 << 20, 1);
      minor = ({32'd0, major} * tan_bound[k]) >> 13;
      minor = minor + $urandom_range(2);
      if (minor != 0) minor = minor - 1;
      if (minor > major) minor = major;
      if ($urandom_range(1)) begin
        x = signed_of(major, $urandom_range(1));
        y = signed_of(minor[MagW-1:0], $urandom_range(1));
      end else begin
        x = signed_of(minor[MagW-1:0], $urandom_range(1));
        y = signed_of(major, $urandom_range(1));
      end
    end else if (kind >= 85) begin
      // equal or nearly equal magnitudes
      major = $urandom & 32'h7FFF_FFFE;
      if (major == 0) major = 1;
      x = signed_of(major, $urandom_range(1));
      y = signed_of(major + $urandom_range(1), $urandom_range(1));
    end
    send_vector(x, y, AngW'($urandom));
  endtask

  task automatic test_zero_and_axes();
    send_vector(0, 0, 8'd0);
    send_vector(0, 0, 8'd255);
    send_vector(0, 0, 8'hA5);
    send_vector(5, 0, 8'd17);
    send_vector(-7, 0, 8'd17);
    send_vector(0, 3, 8'd17);
    send_vector(0, -9, 8'd17);
  endtask

  task automatic test_extremes();
    send_vector(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 8'd0);
    send_vector(-32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 8'd0);
    send_vector(32'sh8000_0000, 32'sh8000_0000, 8'd0);
    send_vector(32'sh8000_0000, 1, 8'd0);
    send_vector(1, 32'sh8000_0000, 8'd0);
    send_vector(32'sh7FFF_FFFF, 1, 8'd0);
    // 256 - 0 must wrap to zero
    send_vector(32'sh7FFF_FFFF, -1, 8'd0);
    send_vector(32'sh8000_0000, 0, 8'hFF);
    send_vector(0, 32'sh8000_0000, 8'hFF);
  endtask

  task automatic test_octants();
    send_vector(100, 37, 8'd0);
    send_vector(37, 100, 8'd0);
    send_vector(100, -37, 8'd0);
    send_vector(37, -100, 8'd0);
    send_vector(-100, 37, 8'd0);
    send_vector(-37, 100, 8'd0);
    send_vector(-100, -37, 8'd0);
    send_vector(-37, -100, 8'd0);
  endtask

  // Random traffic under each idling pattern
  task automatic test_random_traffic();
    int sender_pct [4] = '{0, 81, 0, 11};
    int recv_pct   [4] = '{0, 0, 81, 11};
    for (int p = 0; p < 4; p++) begin
      send_idle_pct = sender_pct[p];
      stall_pct     = recv_pct[p];
      repeat (235) send_random_vector();
    end
  endtask

  // Hold off the receiver while requests keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off_req  = 300;
    repeat (6) send_random_vector();
  endtask

  // Receiver: long hold-off when asked, random stalls otherwise
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk_i) begin : result_check
    angle_expect_t head;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_angles.size() == 0) begin
        report_mismatch($sformatf("angle %0d with no request pending", angle_o));
      end else begin
        head = expected_angles.pop_front();
        if (angle_o !== head.angle)
          report_mismatch($sformatf("x=%0d y=%0d: angle %0d, expected %0d",
                                    head.x, head.y, angle_o, head.angle));
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : main
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_and_axes();
    test_extremes();
    test_octants();
    test_backpressure();
    test_random_traffic();
    in_valid_i <= 1'b0;
    // Drain what is still in flight, then give stray results time to show
    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
